// File: rtl/cau_pkg.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared operation codes, the item record that travels down the cell row,
// and the saturation helpers.
// ---------------------------------------------------------------------------
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 64;
    localparam int REM_W         = 96;
    localparam int ROOT_W        = 32;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_DIV  = 3'd3,
        CMD_CONJ = 3'd4,
        CMD_MAG  = 3'd5,
        CMD_LT   = 3'd6,
        CMD_EQ   = 3'd7
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [DATA_W-1:0]  res_re;
        logic [DATA_W-1:0]  res_im;
        logic               cmp;
        logic               sat;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic               ovf_re;
        logic               ovf_im;
        logic [REM_W-1:0]   rem_re;
        logic [REM_W-1:0]   rem_im;
        logic [PROD_W-1:0]  den;
        logic [DATA_W-1:0]  q_re;
        logic [DATA_W-1:0]  q_im;
        logic [PROD_W-1:0]  sq_rem;
        logic [ROOT_W-1:0]  sq_root;
    } item_t;

    // Clips a sign and magnitude value; bit 32 of the result is the clip flag.
    function automatic logic [DATA_W:0] clip_mag(input logic [PROD_W-1:0] mag,
                                                 input logic neg);
        logic [DATA_W-1:0] lo;
        logic [DATA_W:0]   r;
        lo = mag[DATA_W-1:0];
        if (neg) begin
            if (mag > PROD_W'(64'h8000_0000)) begin
                r = {1'b1, 32'h8000_0000};
            end else begin
                r = {1'b0, (~lo) + 32'd1};
            end
        end else begin
            if (mag > PROD_W'(64'h7FFF_FFFF)) begin
                r = {1'b1, 32'h7FFF_FFFF};
            end else begin
                r = {1'b0, lo};
            end
        end
        return r;
    endfunction

    // Clips a 33-bit two's complement value; bit 32 of the result is the clip flag.
    function automatic logic [DATA_W:0] clip_s33(input logic [DATA_W:0] s);
        logic [DATA_W:0] r;
        if (s[DATA_W] != s[DATA_W-1]) begin
            r = s[DATA_W] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        end else begin
            r = {1'b0, s[DATA_W-1:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/cau_front.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit front end
// Three stages: operand products, exact sums and the simple operations,
// then clipped products and the division and root cell starting values.
// ---------------------------------------------------------------------------
module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output logic                valid,
    output cau_pkg::item_t      item
);

    logic                 s1_valid_reg;
    cau_pkg::cmd_t        s1_cmd_reg;
    logic signed [31:0]   s1_a_re_reg, s1_a_im_reg, s1_b_re_reg, s1_b_im_reg;
    logic signed [63:0]   s1_prod_reg [6];
    logic signed [63:0]   prod_next [6];
    logic signed [31:0]   sq_x, sq_y;

    always_comb
    begin
        sq_x = (cau_pkg::cmd_t'(cmd) == cau_pkg::CMD_MAG) ? a_re : b_re;
        sq_y = (cau_pkg::cmd_t'(cmd) == cau_pkg::CMD_MAG) ? a_im : b_im;
        prod_next[0] = a_re * b_re;
        prod_next[1] = a_im * b_im;
        prod_next[2] = a_re * b_im;
        prod_next[3] = a_im * b_re;
        prod_next[4] = sq_x * sq_x;
        prod_next[5] = sq_y * sq_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_cmd_reg  <= cau_pkg::cmd_t'(cmd);
            s1_a_re_reg <= a_re;
            s1_a_im_reg <= a_im;
            s1_b_re_reg <= b_re;
            s1_b_im_reg <= b_im;
            for (int i = 0; i < 6; i++) begin
                s1_prod_reg[i] <= prod_next[i];
            end
        end
    end

    logic                 s2_valid_reg;
    cau_pkg::cmd_t        s2_cmd_reg;
    logic [31:0]          s2_res_re_reg, s2_res_im_reg;
    logic                 s2_cmp_reg, s2_sat_reg;
    logic                 s2_neg_re_reg, s2_neg_im_reg;
    logic [63:0]          s2_mag_re_reg, s2_mag_im_reg, s2_den_reg;

    logic signed [64:0]   sum_re, sum_im, p1_x, p2_x;
    logic [63:0]          mag_re_next, mag_im_next, den_next;
    logic [31:0]          res_re_next, res_im_next;
    logic                 cmp_next, sat_next;
    logic [32:0]          c_re, c_im;
    logic                 is_div;

    always_comb
    begin
        is_div = (s1_cmd_reg == cau_pkg::CMD_DIV);
        p1_x   = $signed({s1_prod_reg[1][63], s1_prod_reg[1]});
        p2_x   = $signed({s1_prod_reg[2][63], s1_prod_reg[2]});
        sum_re = $signed({s1_prod_reg[0][63], s1_prod_reg[0]}) + (is_div ? p1_x : -p1_x);
        sum_im = $signed({s1_prod_reg[3][63], s1_prod_reg[3]}) + (is_div ? -p2_x : p2_x);
        mag_re_next = sum_re[64] ? 64'(-sum_re) : sum_re[63:0];
        mag_im_next = sum_im[64] ? 64'(-sum_im) : sum_im[63:0];
        den_next    = s1_prod_reg[4] + s1_prod_reg[5];

        c_re        = '0;
        c_im        = '0;
        cmp_next    = 1'b0;
        unique case (s1_cmd_reg)
            cau_pkg::CMD_ADD: begin
                c_re = cau_pkg::clip_s33({s1_a_re_reg[31], s1_a_re_reg}
                                         + {s1_b_re_reg[31], s1_b_re_reg});
                c_im = cau_pkg::clip_s33({s1_a_im_reg[31], s1_a_im_reg}
                                         + {s1_b_im_reg[31], s1_b_im_reg});
            end
            cau_pkg::CMD_SUB: begin
                c_re = cau_pkg::clip_s33({s1_a_re_reg[31], s1_a_re_reg}
                                         - {s1_b_re_reg[31], s1_b_re_reg});
                c_im = cau_pkg::clip_s33({s1_a_im_reg[31], s1_a_im_reg}
                                         - {s1_b_im_reg[31], s1_b_im_reg});
            end
            cau_pkg::CMD_CONJ: begin
                c_re = {1'b0, s1_a_re_reg};
                c_im = cau_pkg::clip_s33(33'd0 - {s1_a_im_reg[31], s1_a_im_reg});
            end
            cau_pkg::CMD_LT: begin
                cmp_next = (s1_a_re_reg == s1_b_re_reg) ? (s1_a_im_reg < s1_b_im_reg)
                                                        : (s1_a_re_reg < s1_b_re_reg);
            end
            cau_pkg::CMD_EQ: begin
                cmp_next = (s1_a_re_reg == s1_b_re_reg) && (s1_a_im_reg == s1_b_im_reg);
            end
            cau_pkg::CMD_MUL, cau_pkg::CMD_DIV, cau_pkg::CMD_MAG: begin
                cmp_next = 1'b0;
            end
        endcase
        res_re_next = c_re[31:0];
        res_im_next = c_im[31:0];
        sat_next    = c_re[32] | c_im[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_res_re_reg <= res_re_next;
            s2_res_im_reg <= res_im_next;
            s2_cmp_reg    <= cmp_next;
            s2_sat_reg    <= sat_next;
            s2_neg_re_reg <= sum_re[64];
            s2_neg_im_reg <= sum_im[64];
            s2_mag_re_reg <= mag_re_next;
            s2_mag_im_reg <= mag_im_next;
            s2_den_reg    <= den_next;
        end
    end

    logic                 s3_valid_reg;
    cau_pkg::item_t       s3_item_reg;
    cau_pkg::item_t       s3_item_next;
    logic [32:0]          m_re, m_im;
    logic [cau_pkg::REM_W-1:0] num_re, num_im, den_top;

    always_comb
    begin
        m_re    = cau_pkg::clip_mag(s2_mag_re_reg >> FRAC_BITS, s2_neg_re_reg);
        m_im    = cau_pkg::clip_mag(s2_mag_im_reg >> FRAC_BITS, s2_neg_im_reg);
        num_re  = cau_pkg::REM_W'(s2_mag_re_reg) << FRAC_BITS;
        num_im  = cau_pkg::REM_W'(s2_mag_im_reg) << FRAC_BITS;
        den_top = cau_pkg::REM_W'(s2_den_reg) << cau_pkg::DATA_W;

        s3_item_next.cmd     = s2_cmd_reg;
        s3_item_next.res_re  = s2_res_re_reg;
        s3_item_next.res_im  = s2_res_im_reg;
        s3_item_next.cmp     = s2_cmp_reg;
        s3_item_next.sat     = s2_sat_reg;
        if (s2_cmd_reg == cau_pkg::CMD_MUL) begin
            s3_item_next.res_re = m_re[31:0];
            s3_item_next.res_im = m_im[31:0];
            s3_item_next.sat    = m_re[32] | m_im[32];
        end
        s3_item_next.dz      = (s2_den_reg == '0);
        s3_item_next.neg_re  = s2_neg_re_reg;
        s3_item_next.neg_im  = s2_neg_im_reg;
        s3_item_next.ovf_re  = (num_re >= den_top);
        s3_item_next.ovf_im  = (num_im >= den_top);
        s3_item_next.rem_re  = num_re;
        s3_item_next.rem_im  = num_im;
        s3_item_next.den     = s2_den_reg;
        s3_item_next.q_re    = '0;
        s3_item_next.q_im    = '0;
        s3_item_next.sq_rem  = s2_den_reg;
        s3_item_next.sq_root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s3_item_reg <= s3_item_next;
        end
    end

    assign valid = s3_valid_reg;
    assign item  = s3_item_reg;

endmodule

// File: rtl/cau_cell.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit cell
// One quotient bit of both divisions and one root bit of the magnitude,
// then hands the item to the next cell.
// ---------------------------------------------------------------------------
module cau_cell #(
    parameter int BIT = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            prev_valid,
    input  cau_pkg::item_t  prev_item,
    output logic            valid,
    output cau_pkg::item_t  item
);

    logic                       valid_reg;
    cau_pkg::item_t             item_reg;
    cau_pkg::item_t             item_next;
    logic [cau_pkg::REM_W-1:0]  sub_den;
    logic [65:0]                trial;

    always_comb
    begin
        item_next = prev_item;
        sub_den   = cau_pkg::REM_W'(prev_item.den) << BIT;
        trial     = (66'(prev_item.sq_root) << (BIT + 1)) | (66'(1) << (2 * BIT));
        if (prev_item.rem_re >= sub_den) begin
            item_next.rem_re    = prev_item.rem_re - sub_den;
            item_next.q_re[BIT] = 1'b1;
        end
        if (prev_item.rem_im >= sub_den) begin
            item_next.rem_im    = prev_item.rem_im - sub_den;
            item_next.q_im[BIT] = 1'b1;
        end
        if ({2'b00, prev_item.sq_rem} >= trial) begin
            item_next.sq_rem       = prev_item.sq_rem - trial[63:0];
            item_next.sq_root[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// File: rtl/cau_finish.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit output stage
// Clips the quotients and the root and holds the result item for the
// receiving side.
// ---------------------------------------------------------------------------
module cau_finish (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                prev_valid,
    input  cau_pkg::item_t      prev_item,
    output logic                valid,
    output logic signed [31:0]  result_re,
    output logic signed [31:0]  result_im,
    output logic                compare_true,
    output logic                divide_by_zero,
    output logic                saturated
);

    logic        valid_reg;
    logic [31:0] re_reg, im_reg, re_next, im_next;
    logic        cmp_reg, dz_reg, sat_reg, cmp_next, dz_next, sat_next;
    logic [32:0] d_re, d_im, root_c;

    always_comb
    begin
        d_re = prev_item.ovf_re
             ? (prev_item.neg_re ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF})
             : cau_pkg::clip_mag(64'(prev_item.q_re), prev_item.neg_re);
        d_im = prev_item.ovf_im
             ? (prev_item.neg_im ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF})
             : cau_pkg::clip_mag(64'(prev_item.q_im), prev_item.neg_im);
        root_c = cau_pkg::clip_mag(64'(prev_item.sq_root), 1'b0);

        re_next  = prev_item.res_re;
        im_next  = prev_item.res_im;
        cmp_next = prev_item.cmp;
        dz_next  = 1'b0;
        sat_next = prev_item.sat;
        if (prev_item.cmd == cau_pkg::CMD_DIV) begin
            if (prev_item.dz) begin
                re_next  = '0;
                im_next  = '0;
                dz_next  = 1'b1;
                sat_next = 1'b0;
            end else begin
                re_next  = d_re[31:0];
                im_next  = d_im[31:0];
                sat_next = d_re[32] | d_im[32];
            end
        end else if (prev_item.cmd == cau_pkg::CMD_MAG) begin
            re_next  = root_c[31:0];
            im_next  = '0;
            sat_next = root_c[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            re_reg  <= re_next;
            im_reg  <= im_next;
            cmp_reg <= cmp_next;
            dz_reg  <= dz_next;
            sat_reg <= sat_next;
        end
    end

    assign valid          = valid_reg;
    assign result_re      = re_reg;
    assign result_im      = im_reg;
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;
    assign saturated      = sat_reg;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate, magnitude and compares on
// signed fixed point complex operands, fully pipelined.
// The pipeline has three front stages, 32 cells that each settle one quotient
// and root bit, and one output stage.
// Throughput is one item per cycle; the whole pipeline holds while the output
// is stalled. Reset clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  result_re,
    output logic signed [31:0]  result_im,
    output logic                compare_true,
    output logic                divide_by_zero,
    output logic                saturated
);

    localparam int CELLS = cau_pkg::ROOT_W;

    logic           en;
    logic           chain_valid [CELLS+1];
    cau_pkg::item_t chain_item  [CELLS+1];

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .cmd      (cmd),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .valid    (chain_valid[0]),
        .item     (chain_item[0])
    );

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        cau_cell #(
            .BIT (CELLS - 1 - i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .prev_valid (chain_valid[i]),
            .prev_item  (chain_item[i]),
            .valid      (chain_valid[i+1]),
            .item       (chain_item[i+1])
        );
    end

    cau_finish u_finish (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .prev_valid     (chain_valid[CELLS]),
        .prev_item      (chain_item[CELLS]),
        .valid          (out_valid),
        .result_re      (result_re),
        .result_im      (result_im),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero),
        .saturated      (saturated)
    );

endmodule
